[hdl/simple_moving_average_assert.svh]
// ---------------------------------------------------------------------------
// simple moving average assertion macros
// shared assertion forms for the moving average block
// ---------------------------------------------------------------------------
`ifndef SIMPLE_MOVING_AVERAGE_ASSERT_SVH
`define SIMPLE_MOVING_AVERAGE_ASSERT_SVH

// condition holds in the same cycle
`define SMA_ASSERT_SAME(label, cond, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (expr)) \
      else $error(msg);

// condition implies expression in the next cycle
`define SMA_ASSERT_NEXT(label, cond, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expr)) \
      else $error(msg);

`endif

[hdl/sma_pkg.sv]
// ---------------------------------------------------------------------------
// sma_pkg
// shared constants and types of the moving average block
// ---------------------------------------------------------------------------
package sma_pkg;

   localparam int WIN_DEPTH = 30;
   localparam int ADDR_W    = $clog2(WIN_DEPTH);
   localparam int SAMPLE_W  = 32;
   localparam int LEN_W     = 5;
   localparam int SUM_W     = 37;
   localparam int DIFF_W    = SAMPLE_W + 1;
   localparam int MAG_W     = SUM_W - 1;
   localparam int CNT_W     = $clog2(MAG_W);
   localparam int CSR_AW    = 3;
   localparam int CSR_DW    = 32;

   localparam logic REG_WINDOW_LENGTH = 1'b0;

   typedef logic signed [SAMPLE_W-1:0] sample_type;

   typedef struct packed {
      logic              clear;
      logic              rd_en;
      logic              wr_en;
      logic [ADDR_W-1:0] addr;
   } win_ctl_type;

endpackage

[hdl/sma_if.sv]
// ---------------------------------------------------------------------------
// sma channel interfaces
// valid/ready channels for requests and averages
// ---------------------------------------------------------------------------
interface sma_req_if;
   logic               valid;
   logic               ready;
   sma_pkg::sample_type sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface sma_rsp_if;
   logic               valid;
   logic               ready;
   sma_pkg::sample_type average;

   modport source (output valid, output average, input ready);
   modport sink   (input valid, input average, output ready);
endinterface

[hdl/sma_window.sv]
// ---------------------------------------------------------------------------
// sma_window
// circular sample store with per-slot valid bits, unwritten slots read zero
// ---------------------------------------------------------------------------
module sma_window (
   input  logic                clock,
   input  logic                reset,
   input  sma_pkg::win_ctl_type ctl,
   input  sma_pkg::sample_type  wr_data,
   output sma_pkg::sample_type  rd_data
);

   sma_pkg::sample_type              mem [sma_pkg::WIN_DEPTH];
   logic [sma_pkg::WIN_DEPTH-1:0]    valid_ff;
   logic [sma_pkg::WIN_DEPTH-1:0]    valid_in;
   sma_pkg::sample_type              rd_ff;
   logic                             rd_valid_ff;

   always_comb begin
      valid_in = valid_ff;
      if (ctl.clear) begin
         valid_in = '0;
      end else if (ctl.wr_en) begin
         valid_in[ctl.addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (ctl.rd_en) begin
            rd_valid_ff <= valid_ff[ctl.addr];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[ctl.addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_ff <= mem[ctl.addr];
      end
   end

   assign rd_data = rd_valid_ff ? rd_ff : '0;

endmodule

[hdl/sma_div.sv]
// ---------------------------------------------------------------------------
// sma_div
// restoring divider, one quotient bit per cycle, unsigned magnitude
// ---------------------------------------------------------------------------
module sma_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [sma_pkg::MAG_W-1:0]    dividend,
   input  logic [sma_pkg::LEN_W-1:0]    divisor,
   output logic                         done,
   output logic [sma_pkg::SAMPLE_W-1:0] quotient
);

   logic                         busy_ff;
   logic                         busy_in;
   logic                         done_ff;
   logic                         done_in;
   logic [sma_pkg::CNT_W-1:0]    cnt_ff;
   logic [sma_pkg::CNT_W-1:0]    cnt_in;
   logic [sma_pkg::LEN_W-1:0]    rem_ff;
   logic [sma_pkg::LEN_W-1:0]    rem_in;
   logic [sma_pkg::MAG_W-1:0]    dq_ff;
   logic [sma_pkg::MAG_W-1:0]    dq_in;
   logic [sma_pkg::LEN_W:0]      trial;
   logic [sma_pkg::LEN_W:0]      diff;
   logic                         ge;

   always_comb begin
      trial   = {rem_ff, dq_ff[sma_pkg::MAG_W-1]};
      diff    = trial - {1'b0, divisor};
      ge      = trial >= {1'b0, divisor};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dq_in   = dq_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         dq_in   = dividend;
      end else if (busy_ff) begin
         rem_in = ge ? diff[sma_pkg::LEN_W-1:0] : trial[sma_pkg::LEN_W-1:0];
         dq_in  = {dq_ff[sma_pkg::MAG_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == sma_pkg::CNT_W'(sma_pkg::MAG_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dq_ff  <= dq_in;
   end

   assign done     = done_ff;
   assign quotient = dq_ff[sma_pkg::SAMPLE_W-1:0];

endmodule

[hdl/simple_moving_average.sv]
// ---------------------------------------------------------------------------
// simple_moving_average
// moving average of signed 32-bit samples over a window of 1 to 30 slots
// ---------------------------------------------------------------------------
// usage
//   req_if carries one signed sample per request; rsp_if returns one
//   average per request, the window sum divided by the window length,
//   truncated toward zero. unwritten slots count as zero.
//   the apb port holds window_length at address 0 (reset value 1); a write
//   of 1 to 30 in pwdata[4:0] sets it and clears the window; others do not.
// timing
//   a request is taken only in idle; it then passes the states read, sum,
//   start, div and done, and the average becomes valid as the block returns
//   to idle, where the next request can be taken at once. the div state lasts
//   while the restoring divider (36 quotient bits, one per cycle) runs.
// reset and stall
//   synchronous reset clears the window, write position and sum, and sets
//   the length to 1. the average waits in an output register; a new request
//   is accepted while it waits, and a later average is held back until it
//   is taken.
// ---------------------------------------------------------------------------
`include "simple_moving_average_assert.svh"

module simple_moving_average (
   input  logic                          clock,
   input  logic                          reset,
   sma_req_if.sink                       req_if,
   sma_rsp_if.source                     rsp_if,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [sma_pkg::CSR_AW-1:0]    paddr,
   input  logic [sma_pkg::CSR_DW-1:0]    pwdata,
   output logic [sma_pkg::CSR_DW-1:0]    prdata,
   output logic                          pready
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_READ  = 3'd1;
   localparam logic [2:0] S_SUM   = 3'd2;
   localparam logic [2:0] S_START = 3'd3;
   localparam logic [2:0] S_DIV   = 3'd4;
   localparam logic [2:0] S_DONE  = 3'd5;

   logic [2:0]                        state_ff;
   logic [2:0]                        state_in;
   sma_pkg::sample_type               sample_ff;
   sma_pkg::sample_type               sample_in;
   logic signed [sma_pkg::DIFF_W-1:0] diff_ff;
   logic signed [sma_pkg::DIFF_W-1:0] diff_in;
   logic signed [sma_pkg::SUM_W-1:0]  sum_ff;
   logic signed [sma_pkg::SUM_W-1:0]  sum_in;
   logic [sma_pkg::ADDR_W-1:0]        pos_ff;
   logic [sma_pkg::ADDR_W-1:0]        pos_in;
   logic [sma_pkg::LEN_W-1:0]         length_ff;
   logic [sma_pkg::LEN_W-1:0]         length_in;
   logic                              neg_ff;
   logic                              neg_in;
   logic [sma_pkg::SAMPLE_W-1:0]      quot_ff;
   logic [sma_pkg::SAMPLE_W-1:0]      quot_in;
   logic                              rsp_valid_ff;
   logic                              rsp_valid_in;
   sma_pkg::sample_type               avg_ff;
   sma_pkg::sample_type               avg_in;

   logic                              req_take;
   logic                              cfg_wr;
   logic [sma_pkg::LEN_W-1:0]         cfg_len;
   logic                              cfg_load;
   sma_pkg::win_ctl_type              win_ctl;
   sma_pkg::sample_type               old_sample;
   logic                              div_start;
   logic                              div_done;
   logic [sma_pkg::SUM_W-1:0]         sum_abs;
   logic [sma_pkg::SAMPLE_W-1:0]      div_quot;

   assign req_take = req_if.valid && req_if.ready;
   assign cfg_wr   = psel && penable && pwrite && pready;
   assign cfg_len  = pwdata[sma_pkg::LEN_W-1:0];
   assign cfg_load = cfg_wr && (paddr[2] == sma_pkg::REG_WINDOW_LENGTH) &&
                     (cfg_len != '0) && (cfg_len <= sma_pkg::LEN_W'(sma_pkg::WIN_DEPTH));

   assign pready = 1'b1;
   assign prdata = {{(sma_pkg::CSR_DW - sma_pkg::LEN_W){1'b0}}, length_ff};

   assign win_ctl.clear = cfg_load;
   assign win_ctl.rd_en = req_take;
   assign win_ctl.wr_en = (state_ff == S_SUM);
   assign win_ctl.addr  = pos_ff;

   assign div_start = (state_ff == S_START);
   assign sum_abs   = sum_ff[sma_pkg::SUM_W-1] ? -sum_ff : sum_ff;

   sma_window u_window (
      .clock   (clock),
      .reset   (reset),
      .ctl     (win_ctl),
      .wr_data (sample_ff),
      .rd_data (old_sample)
   );

   sma_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_abs[sma_pkg::MAG_W-1:0]),
      .divisor  (length_ff),
      .done     (div_done),
      .quotient (div_quot)
   );

   always_comb begin
      state_in     = state_ff;
      sample_in    = sample_ff;
      diff_in      = diff_ff;
      sum_in       = sum_ff;
      pos_in       = pos_ff;
      length_in    = length_ff;
      neg_in       = neg_ff;
      quot_in      = quot_ff;
      avg_in       = avg_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               sample_in = req_if.sample;
               state_in  = S_READ;
            end
         end
         S_READ: begin
            diff_in  = sma_pkg::DIFF_W'(sample_ff) - sma_pkg::DIFF_W'(old_sample);
            state_in = S_SUM;
         end
         S_SUM: begin
            sum_in = sum_ff + sma_pkg::SUM_W'(diff_ff);
            if (pos_ff == sma_pkg::ADDR_W'(length_ff - 1'b1)) begin
               pos_in = '0;
            end else begin
               pos_in = pos_ff + 1'b1;
            end
            state_in = S_START;
         end
         S_START: begin
            neg_in   = sum_ff[sma_pkg::SUM_W-1];
            state_in = S_DIV;
         end
         S_DIV: begin
            if (div_done) begin
               quot_in  = div_quot;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               avg_in       = neg_ff ? -quot_ff : quot_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      if (cfg_load) begin
         length_in = cfg_len;
         sum_in    = '0;
         pos_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         sum_ff       <= '0;
         pos_ff       <= '0;
         length_ff    <= sma_pkg::LEN_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         pos_ff       <= pos_in;
         length_ff    <= length_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff <= sample_in;
      diff_ff   <= diff_in;
      neg_ff    <= neg_in;
      quot_ff   <= quot_in;
      avg_ff    <= avg_in;
   end

   assign req_if.ready   = (state_ff == S_IDLE);
   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.average = avg_ff;

   `SMA_ASSERT_NEXT(a_take_reads, req_take, state_ff == S_READ,
                    "accepted request did not start a window read")
   `SMA_ASSERT_SAME(a_pos_in_window, 1'b1, pos_ff < sma_pkg::ADDR_W'(length_ff),
                    "write position outside window")
   `SMA_ASSERT_SAME(a_len_range, 1'b1,
                    (length_ff != '0) && (length_ff <= sma_pkg::LEN_W'(sma_pkg::WIN_DEPTH)),
                    "window length out of range")
   `SMA_ASSERT_SAME(a_done_in_div, div_done, state_ff == S_DIV,
                    "divider finished outside divide state")

endmodule
